// ===== rtl/udrw_pkg.sv =====
// shared types, widths and codes for the uniform dice block
// no dependencies; imported by every module of the block
`default_nettype none

package udrw_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int SIDES_W     = 32;
  localparam int WORD_W      = 32;
  localparam int ROLL_W      = 32;
  localparam int BASE_W      = 31;
  localparam int POOL_W      = 64;
  localparam int STATUS_W    = 2;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 32;
  localparam int MUL_CNT_W   = $clog2(BASE_W);
  localparam int DIV_CNT_W   = $clog2(POOL_W);

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DISCARD = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BUSY    = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_FIXED_SIDES = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_BASE = 4'd1;

  typedef struct packed {
    logic                mode;
    logic [SIDES_W-1:0]  sides;
    logic [WORD_W-1:0]   entropy_word;
  } in_item_t;

  typedef struct packed {
    logic                roll_valid;
    logic [ROLL_W-1:0]   roll_value;
    logic                need_entropy;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  typedef struct packed {
    logic               start;
    logic [BASE_W-1:0]  base;
    logic [WORD_W-1:0]  word;
    logic [POOL_W-1:0]  range;
    logic [POOL_W-1:0]  pool;
  } mul_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [POOL_W-1:0]  range;
    logic [POOL_W-1:0]  pool;
  } mul_res_t;

  typedef struct packed {
    logic                   start;
    logic [POOL_W-1:0]      dividend;
    logic [VALUE_WIDTH-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                   busy;
    logic                   done;
    logic [POOL_W-1:0]      quot;
    logic [VALUE_WIDTH-1:0] rem;
  } div_res_t;

endpackage

`default_nettype wire

// ===== rtl/udrw_mul.sv =====
// bit-serial scaling of pool range and pool value by the source base
// depends on udrw_pkg; one base bit per cycle, lsb first
`default_nettype none

module udrw_mul import udrw_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire mul_req_t req,
  output mul_res_t      res
);

  logic [POOL_W-1:0]    acc_range;
  logic [POOL_W-1:0]    acc_pool;
  logic [POOL_W-1:0]    mc_range;
  logic [POOL_W-1:0]    mc_pool;
  logic [BASE_W-1:0]    bits;
  logic [MUL_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + MUL_CNT_W'(1);
        if (cnt == MUL_CNT_W'(BASE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // word seeds the pool accumulator, so the end value is pool*base+word
  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_range <= '0;
      acc_pool  <= POOL_W'(req.word);
      mc_range  <= req.range;
      mc_pool   <= req.pool;
      bits      <= req.base;
    end else if (busy) begin
      if (bits[0]) begin
        acc_range <= acc_range + mc_range;
        acc_pool  <= acc_pool + mc_pool;
      end
      mc_range <= {mc_range[POOL_W-2:0], 1'b0};
      mc_pool  <= {mc_pool[POOL_W-2:0], 1'b0};
      bits     <= {1'b0, bits[BASE_W-1:1]};
    end
  end

  assign res.busy  = busy;
  assign res.done  = done;
  assign res.range = acc_range;
  assign res.pool  = acc_pool;

endmodule

`default_nettype wire

// ===== rtl/udrw_div_lane.sv =====
// restoring divider lane, one quotient bit per cycle
// depends on udrw_pkg; 64-bit dividend over a VALUE_WIDTH divisor
`default_nettype none

module udrw_div_lane import udrw_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_res_t      res
);

  logic [POOL_W-1:0]      quo;
  logic [VALUE_WIDTH-1:0] rem;
  logic [VALUE_WIDTH-1:0] dvs;
  logic [DIV_CNT_W-1:0]   cnt;
  logic                   busy;
  logic                   done;
  logic [VALUE_WIDTH:0]   shifted;
  logic [VALUE_WIDTH:0]   diff;
  logic                   ge;

  always_comb begin
    shifted = {rem, quo[POOL_W-1]};
    ge      = shifted >= {1'b0, dvs};
    diff    = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(POOL_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      quo <= {quo[POOL_W-2:0], ge};
      rem <= ge ? diff[VALUE_WIDTH-1:0] : shifted[VALUE_WIDTH-1:0];
    end
  end

  assign res.busy = busy;
  assign res.done = done;
  assign res.quot = quo;
  assign res.rem  = rem;

endmodule

`default_nettype wire

// ===== rtl/uniform_dice_from_random_words.sv =====
// uniform dice from random words: top level with control, pool state and result register
// items that need no arithmetic go from acceptance through res and ST_FIN into the result register
// an absorbed word passes through the serial multiplier, a decision through both divider lanes
// result stalls hold an item in ST_FIN; one item in work
// reset (synchronous, active high) clears the pool to 0 over range 1, no roll pending
// depends on udrw_pkg, udrw_mul, udrw_div_lane
`default_nettype none

module uniform_dice_from_random_words import udrw_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // request and entropy items
  input  wire logic                   item_valid,
  output logic                        item_stall,
  input  wire in_item_t               item,
  // result items
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output out_item_t                   result,
  // configuration writes
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  // control states
  localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for an item
  localparam logic [1:0] ST_MUL  = 2'd1;  // absorbing an entropy word
  localparam logic [1:0] ST_DIV  = 2'd2;  // reducing the pool by the sides
  localparam logic [1:0] ST_FIN  = 2'd3;  // handing the result to the output register

  logic [1:0]             state;

  // configuration
  logic [VALUE_WIDTH-1:0] fixed_sides;
  logic [BASE_W-1:0]      source_base;

  // entropy pool: value is uniform over 0..range-1
  logic [POOL_W-1:0]      pool_value;
  logic [POOL_W-1:0]      pool_range;
  logic                   roll_pending;
  logic [VALUE_WIDTH-1:0] pending_sides;

  // result waiting for the output register
  out_item_t              res;

  mul_req_t               mul_req;
  mul_res_t               mul_res;
  div_req_t               pool_req;
  div_req_t               range_req;
  div_res_t               pool_div;
  div_res_t               range_div;

  logic                   accept;
  logic [VALUE_WIDTH-1:0] req_sides;
  logic                   word_ok;
  logic                   range_covers;
  logic                   mul_covers;
  logic                   start_idle;
  logic                   start_mul;
  logic [POOL_W-1:0]      cut;
  logic                   roll_ok;
  logic                   out_free;

  assign item_stall = state != ST_IDLE;
  assign cfg_ready  = 1'b1;
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;

  always_comb begin
    // fixed sides win over the sides of the request
    req_sides    = (fixed_sides != '0) ? fixed_sides : item.sides[VALUE_WIDTH-1:0];
    word_ok      = item.entropy_word < WORD_W'(source_base);
    range_covers = pool_range >= POOL_W'(req_sides);
    mul_covers   = mul_res.range >= POOL_W'(pending_sides);
    // leftover entropy already covers a fresh request
    start_idle   = accept && !item.mode && !roll_pending &&
                   (req_sides >= VALUE_WIDTH'(2)) && range_covers;
    start_mul    = (state == ST_MUL) && mul_res.done && mul_covers;
    // cut at the largest multiple of sides; a pool below it is a fair roll
    cut          = pool_range - POOL_W'(range_div.rem);
    roll_ok      = pool_value < cut;
  end

  always_comb begin
    mul_req.start = accept && item.mode && roll_pending && word_ok;
    mul_req.base  = source_base;
    mul_req.word  = item.entropy_word;
    mul_req.range = pool_range;
    mul_req.pool  = pool_value;

    pool_req.start     = start_idle || start_mul;
    range_req.start    = start_idle || start_mul;
    // after a multiply the dividends come straight from the multiplier
    pool_req.dividend  = (state == ST_MUL) ? mul_res.pool : pool_value;
    range_req.dividend = (state == ST_MUL) ? mul_res.range : pool_range;
    pool_req.divisor   = (state == ST_MUL) ? pending_sides : req_sides;
    range_req.divisor  = pool_req.divisor;
  end

  udrw_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .res (mul_res)
  );

  udrw_div_lane u_pool_div (
    .clk (clk),
    .rst (rst),
    .req (pool_req),
    .res (pool_div)
  );

  udrw_div_lane u_range_div (
    .clk (clk),
    .rst (rst),
    .req (range_req),
    .res (range_div)
  );

  // configuration registers, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      fixed_sides <= '0;
      source_base <= BASE_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FIXED_SIDES: fixed_sides <= cfg_data[VALUE_WIDTH-1:0];
        CFG_SOURCE_BASE: source_base <= cfg_data[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // control and pool state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      pool_value    <= '0;
      pool_range    <= POOL_W'(1);
      roll_pending  <= 1'b0;
      pending_sides <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (!item.mode) begin
              if (roll_pending) begin
                // request while busy
                state <= ST_FIN;
              end else if (req_sides < VALUE_WIDTH'(2)) begin
                // one or no outcome: roll 0 at once
                state <= ST_FIN;
              end else begin
                pending_sides <= req_sides;
                roll_pending  <= 1'b1;
                state         <= range_covers ? ST_DIV : ST_FIN;
              end
            end else if (roll_pending && word_ok) begin
              state <= ST_MUL;
            end else begin
              // unneeded or out-of-range word
              state <= ST_FIN;
            end
          end
        end
        ST_MUL: begin
          if (mul_res.done) begin
            pool_range <= mul_res.range;
            pool_value <= mul_res.pool;
            state      <= mul_covers ? ST_DIV : ST_FIN;
          end
        end
        ST_DIV: begin
          if (range_div.done) begin
            if (roll_ok) begin
              pool_value   <= pool_div.quot;
              pool_range   <= range_div.quot;
              roll_pending <= 1'b0;
            end else begin
              // keep only the leftover and wait for more entropy
              pool_value <= POOL_W'(pool_div.rem);
              pool_range <= POOL_W'(range_div.rem);
            end
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result of the item in work
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          res.roll_value <= '0;
          if (!item.mode && roll_pending) begin
            // request while busy
            res.roll_valid   <= 1'b0;
            res.need_entropy <= 1'b1;
            res.status       <= ST_BUSY;
          end else if (!item.mode && (req_sides < VALUE_WIDTH'(2))) begin
            res.roll_valid   <= 1'b1;
            res.need_entropy <= 1'b0;
            res.status       <= ST_OK;
          end else if (!item.mode) begin
            res.roll_valid   <= 1'b0;
            res.need_entropy <= 1'b1;
            res.status       <= ST_OK;
          end else if (roll_pending && word_ok) begin
            res.roll_valid   <= 1'b0;
            res.need_entropy <= 1'b1;
            res.status       <= ST_OK;
          end else begin
            res.roll_valid   <= 1'b0;
            res.need_entropy <= roll_pending;
            res.status       <= ST_DISCARD;
          end
        end
      end
      ST_MUL: begin
        if (mul_res.done) begin
          res.roll_valid   <= 1'b0;
          res.roll_value   <= '0;
          res.need_entropy <= 1'b1;
          res.status       <= ST_OK;
        end
      end
      ST_DIV: begin
        if (range_div.done) begin
          res.roll_valid   <= roll_ok;
          res.roll_value   <= roll_ok ? ROLL_W'(pool_div.rem) : '0;
          res.need_entropy <= !roll_ok;
          res.status       <= ST_OK;
        end
      end
      default: ;
    endcase
  end

  // output register parts the result side from the work
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      result <= res;
    end
  end

`ifndef SYNTHESIS
  // both divider lanes run in lock step
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    pool_div.done == range_div.done)
    else $error("divider lanes out of step");

  // an accepted item always leaves idle
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("item accepted without starting work");

  // the pool stays below its range between items
  a_pool_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> pool_value < pool_range)
    else $error("pool value not below pool range");

  // a finished roll leaves nothing pending
  a_roll_clears_pending: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.roll_valid |-> !result.need_entropy)
    else $error("finished roll flagged as waiting");

  // multiplier and range divider never work at once
  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mul_res.busy && range_div.busy))
    else $error("multiplier and divider busy together");
`endif

endmodule

`default_nettype wire
